// File: hdl/bbo1_pkg.sv
// Shared constants and types for the order-1 B-spline basis step.
// Depends on nothing; imported by bbo1_div and bspline_basis_order1_step.
`timescale 1ns / 1ps

package bbo1_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int NUM_KNOTS      = 5;
    localparam int NUM_PREV       = 4;
    localparam int NUM_NEW        = 3;
    localparam int NUM_TERMS      = 2 * NUM_NEW;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_KNOT_0 = 3'd0,
        IDX_KNOT_1 = 3'd1,
        IDX_KNOT_2 = 3'd2,
        IDX_KNOT_3 = 3'd3,
        IDX_KNOT_4 = 3'd4
    } cfg_idx_t;

    function automatic int knot_reset_val(int k);
        unique case (k)
            IDX_KNOT_0: return -4096;
            IDX_KNOT_1: return -3277;
            IDX_KNOT_2: return -2458;
            IDX_KNOT_3: return -1638;
            IDX_KNOT_4: return -819;
            default:    return 0;
        endcase
    endfunction

endpackage

// File: hdl/bbo1_div.sv
// Pipelined restoring divider: one quotient bit per register stage, truncating.
// Depends on bbo1_pkg for default widths.
`timescale 1ns / 1ps

module bbo1_div
    import bbo1_pkg::*;
#(
    parameter int NUM_W = 2 * DATA_WIDTH_DEF,
    parameter int DEN_W = DATA_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot
);

    logic [DEN_W-1:0] rem_reg  [NUM_W];
    logic [NUM_W-1:0] num_reg  [NUM_W];
    logic [NUM_W-1:0] quot_reg [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] num_cur;
        logic [NUM_W-1:0] quot_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W+1:0] diff;
        logic             borrow;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign num_cur = num_in;
            assign quot_in = '0;
        end
        else begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign num_cur = num_reg[s-1];
            assign quot_in = quot_reg[s-1];
        end

        assign trial  = {rem_in, num_cur[NUM_W-1]};
        assign diff   = {1'b0, trial} - {2'b00, den};
        assign borrow = diff[DEN_W+1];

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= borrow ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
            num_reg[s]  <= num_cur << 1;
            quot_reg[s] <= {quot_in[NUM_W-2:0], ~borrow};
        end
    end

    assign quot = quot_reg[NUM_W-1];

endmodule

// File: hdl/bspline_basis_order1_step.sv
// Top level of the order-1 B-spline basis step: knot registers, datapath pipeline.
// Depends on bbo1_pkg and bbo1_div.
`timescale 1ns / 1ps
//
// Usage:
//   Input: a word (point_x, prev_basis_0..3, last_point_in) is taken at a rising
//   edge with start high and busy low. busy stays low, so a word may enter on
//   every cycle; throughput is one word per cycle.
//   Output: done is high for one cycle with point_x_out, new_basis_0..2 and
//   last_point_out; the receiver takes the word at the edge ending that cycle.
//   Depth: the pipeline length is set by the bit-per-stage dividers,
//   one per term, six in all.
//   Configuration: knot_0..knot_4 are written through cfg_valid/cfg_ready with
//   cfg_index and cfg_data; cfg_ready is always high, writes beyond knot_4 are
//   dropped. Write only while no word is in flight.
//   Reset: rst_n clears the pipeline valid bits and loads the default knots;
//   words in flight are dropped. The receiver cannot stall, so there is no
//   back pressure anywhere in the pipeline.
//
module bspline_basis_order1_step
    import bbo1_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] point_x,
    input  logic signed [DATA_WIDTH-1:0] prev_basis_0,
    input  logic signed [DATA_WIDTH-1:0] prev_basis_1,
    input  logic signed [DATA_WIDTH-1:0] prev_basis_2,
    input  logic signed [DATA_WIDTH-1:0] prev_basis_3,
    input  logic                         last_point_in,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [DATA_WIDTH-1:0]        cfg_data,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] point_x_out,
    output logic signed [DATA_WIDTH-1:0] new_basis_0,
    output logic signed [DATA_WIDTH-1:0] new_basis_1,
    output logic signed [DATA_WIDTH-1:0] new_basis_2,
    output logic                         last_point_out
);

    localparam int W      = DATA_WIDTH;
    localparam int DIFF_W = W + 1;
    localparam int PROD_W = 2 * W + 1;
    localparam int NUM_W  = 2 * W;
    localparam int TERM_W = NUM_W + 1;
    localparam int SUM_W  = NUM_W + 2;
    localparam int DEPTH  = NUM_W + 6;
    localparam int F1_IDX = NUM_W + 4;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [W-1:0]    x;
        logic                   last;
        logic [NUM_TERMS-1:0]   psign;
    } side_t;

    logic                     accept;
    logic signed [W-1:0]      knot_reg [NUM_KNOTS];
    logic signed [W-1:0]      prev_in  [NUM_PREV];

    logic signed [DIFF_W-1:0] den_a_reg, den_b_reg;
    logic [W-1:0]             dmag_a_reg, dmag_b_reg;
    logic                     dneg_a_reg, dneg_b_reg;
    logic                     dzero_a_reg, dzero_b_reg;

    logic [DEPTH-1:0]         vld_reg;
    side_t                    side_reg [DEPTH];

    logic signed [DIFF_W-1:0] diff1_reg [NUM_TERMS];
    logic signed [W-1:0]      n01_reg   [NUM_PREV];
    logic signed [PROD_W-1:0] prod2_reg [NUM_TERMS];
    logic signed [PROD_W-1:0] abs_val   [NUM_TERMS];
    logic [NUM_W-1:0]         mag3_reg  [NUM_TERMS];
    logic [NUM_W-1:0]         num4_reg  [NUM_TERMS];
    logic [NUM_W-1:0]         quot      [NUM_TERMS];
    logic signed [TERM_W-1:0] term_reg  [NUM_TERMS];
    logic signed [W-1:0]      basis_reg [NUM_NEW];
    logic signed [W-1:0]      basis_next [NUM_NEW];
    logic [CNT_W-1:0]         flight_cnt_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    assign prev_in[0] = prev_basis_0;
    assign prev_in[1] = prev_basis_1;
    assign prev_in[2] = prev_basis_2;
    assign prev_in[3] = prev_basis_3;

    // Knot registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < NUM_KNOTS; k++) begin
                knot_reg[k] <= W'(knot_reset_val(k));
            end
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                IDX_KNOT_0: knot_reg[0] <= cfg_data;
                IDX_KNOT_1: knot_reg[1] <= cfg_data;
                IDX_KNOT_2: knot_reg[2] <= cfg_data;
                IDX_KNOT_3: knot_reg[3] <= cfg_data;
                IDX_KNOT_4: knot_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Denominators, static between configuration writes
    always_ff @(posedge clk)
    begin
        den_a_reg   <= DIFF_W'(knot_reg[1]) - DIFF_W'(knot_reg[0]);
        den_b_reg   <= DIFF_W'(knot_reg[2]) - DIFF_W'(knot_reg[1]);
        dneg_a_reg  <= den_a_reg[DIFF_W-1];
        dneg_b_reg  <= den_b_reg[DIFF_W-1];
        dzero_a_reg <= (den_a_reg == '0);
        dzero_b_reg <= (den_b_reg == '0);
        dmag_a_reg  <= den_a_reg[DIFF_W-1] ? W'(-den_a_reg) : W'(den_a_reg);
        dmag_b_reg  <= den_b_reg[DIFF_W-1] ? W'(-den_b_reg) : W'(den_b_reg);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= {vld_reg[DEPTH-2:0], accept};
        end
    end

    // Sideband shift line; capture product signs entering stage 3
    for (genvar k = 0; k < DEPTH; k++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (k == 0) begin
                side_reg[k] <= '{x: point_x, last: last_point_in, psign: '0};
            end
            else if (k == 2) begin
                side_reg[k].x    <= side_reg[k-1].x;
                side_reg[k].last <= side_reg[k-1].last;
                for (int j = 0; j < NUM_TERMS; j++) begin
                    side_reg[k].psign[j] <= prod2_reg[j][PROD_W-1];
                end
            end
            else begin
                side_reg[k] <= side_reg[(k > 0) ? k-1 : 0];
            end
        end
    end

    // Stage 1: differences
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_NEW; i++) begin
            diff1_reg[i]           <= DIFF_W'(point_x) - DIFF_W'(knot_reg[i]);
            diff1_reg[i + NUM_NEW] <= DIFF_W'(knot_reg[i + 2]) - DIFF_W'(point_x);
        end
        for (int i = 0; i < NUM_PREV; i++) begin
            n01_reg[i] <= prev_in[i];
        end
    end

    // Stage 2: products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_NEW; i++) begin
            prod2_reg[i]           <= diff1_reg[i] * n01_reg[i];
            prod2_reg[i + NUM_NEW] <= diff1_reg[i + NUM_NEW] * n01_reg[i + 1];
        end
    end

    // Stage 3: magnitudes
    always_comb
    begin
        for (int j = 0; j < NUM_TERMS; j++) begin
            abs_val[j] = prod2_reg[j][PROD_W-1] ? -prod2_reg[j] : prod2_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_TERMS; j++) begin
            mag3_reg[j] <= abs_val[j][NUM_W-1:0];
        end
    end

    // Stage 4: add half the divisor for round-to-nearest
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_NEW; j++) begin
            num4_reg[j] <= mag3_reg[j] + NUM_W'(dmag_a_reg >> 1);
            num4_reg[j + NUM_NEW] <= mag3_reg[j + NUM_NEW] + NUM_W'(dmag_b_reg >> 1);
        end
    end

    for (genvar j = 0; j < NUM_TERMS; j++) begin : g_div
        bbo1_div #(
            .NUM_W (NUM_W),
            .DEN_W (W)
        ) u_div (
            .clk    (clk),
            .num_in (num4_reg[j]),
            .den    ((j < NUM_NEW) ? dmag_a_reg : dmag_b_reg),
            .quot   (quot[j])
        );
    end

    // Stage F1: apply sign, drop terms with zero divisor
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_NEW; j++) begin
            if (dzero_a_reg)
                term_reg[j] <= '0;
            else if (side_reg[F1_IDX-1].psign[j] ^ dneg_a_reg)
                term_reg[j] <= -$signed({1'b0, quot[j]});
            else
                term_reg[j] <= $signed({1'b0, quot[j]});

            if (dzero_b_reg)
                term_reg[j + NUM_NEW] <= '0;
            else if (side_reg[F1_IDX-1].psign[j + NUM_NEW] ^ dneg_b_reg)
                term_reg[j + NUM_NEW] <= -$signed({1'b0, quot[j + NUM_NEW]});
            else
                term_reg[j + NUM_NEW] <= $signed({1'b0, quot[j + NUM_NEW]});
        end
    end

    // Stage F2: add and saturate
    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        for (int i = 0; i < NUM_NEW; i++) begin
            sum = SUM_W'(term_reg[i]) + SUM_W'(term_reg[i + NUM_NEW]);
            if (sum[SUM_W-1:W-1] == {(SUM_W-W+1){sum[SUM_W-1]}})
                basis_next[i] = sum[W-1:0];
            else if (sum[SUM_W-1])
                basis_next[i] = {1'b1, {(W-1){1'b0}}};
            else
                basis_next[i] = {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_NEW; i++) begin
            basis_reg[i] <= basis_next[i];
        end
    end

    assign done           = vld_reg[DEPTH-1];
    assign point_x_out    = side_reg[DEPTH-1].x;
    assign last_point_out = side_reg[DEPTH-1].last;
    assign new_basis_0    = basis_reg[0];
    assign new_basis_1    = basis_reg[1];
    assign new_basis_2    = basis_reg[2];

    // Words in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            flight_cnt_reg <= '0;
        end
        else begin
            flight_cnt_reg <= flight_cnt_reg + CNT_W'(accept) - CNT_W'(done);
        end
    end

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> ##(DEPTH-1) done)
        else $error("result not delivered at pipeline depth");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> flight_cnt_reg != '0)
        else $error("result without a word in flight");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flight_cnt_reg <= CNT_W'(DEPTH))
        else $error("more words in flight than pipeline stages");

    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[F1_IDX] && $past(dzero_a_reg) |->
            term_reg[0] == '0 && term_reg[1] == '0 && term_reg[2] == '0)
        else $error("term with zero divisor not dropped");

endmodule
